// ===== rtl/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types and constants for the spectral projection bin core.
// ----------------------------------------------------------------------------
`default_nettype none

package sdp_pkg;

  localparam int COORD_W  = 10;
  localparam int SIZE_W   = 11;
  localparam int SCALE_W  = 48;
  localparam int WAVE_W   = 11;
  localparam int K2_W     = 22;
  localparam int CFG_A_W  = 3;
  localparam int MAX_GRID = 1024;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(256);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(64'd16777216);

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SIZE_DIM1  = 3'd0,
    CFG_SIZE_DIM2  = 3'd1,
    CFG_SIZE_DIM3  = 3'd2,
    CFG_NORM_SCALE = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic vld;
    logic neg;
    logic zero;
  } sdp_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spectral_divfree_projection_bin_core.sv =====
// ----------------------------------------------------------------------------
// spectral_divfree_projection_bin_core
// Gradient of the inverse Laplacian of the scaled divergence for one
// spectral bin of a 3-D vector field.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         start_i & !busy_o         coord1..3_i, comp1..3_re/im_i
// result    out        valid_o (one cycle)       proj1..3_re/im_o
// config    in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One bin per cycle; the front stages and the dividend stage feed the
// bit-per-stage quotient pipeline. busy_o stays low.
// Reset clears the valid bits and loads the register defaults.
// No stalls: results leave on valid_o and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_divfree_projection_bin_core import sdp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_A_W-1:0]         cfg_addr_i,
  input  wire logic [SCALE_W-1:0]         cfg_wdata_i,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [COORD_W-1:0]         coord1_i,
  input  wire logic [COORD_W-1:0]         coord2_i,
  input  wire logic [COORD_W-1:0]         coord3_i,
  input  wire logic [SAMPLE_WIDTH-1:0]    comp1_re_i,
  input  wire logic [SAMPLE_WIDTH-1:0]    comp1_im_i,
  input  wire logic [SAMPLE_WIDTH-1:0]    comp2_re_i,
  input  wire logic [SAMPLE_WIDTH-1:0]    comp2_im_i,
  input  wire logic [SAMPLE_WIDTH-1:0]    comp3_re_i,
  input  wire logic [SAMPLE_WIDTH-1:0]    comp3_im_i,
  output logic                            valid_o,
  output logic [SAMPLE_WIDTH-1:0]         proj1_re_o,
  output logic [SAMPLE_WIDTH-1:0]         proj1_im_o,
  output logic [SAMPLE_WIDTH-1:0]         proj2_re_o,
  output logic [SAMPLE_WIDTH-1:0]         proj2_im_o,
  output logic [SAMPLE_WIDTH-1:0]         proj3_re_o,
  output logic [SAMPLE_WIDTH-1:0]         proj3_im_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int PW   = SW + WAVE_W;
  localparam int SSW  = SW + 13;
  localparam int MW   = SW + 12;
  localparam int ML   = (MW + 1) / 2;
  localparam int MH   = MW - ML;
  localparam int NL   = SCALE_W / 2;
  localparam int PPW  = ML + NL;
  localparam int PRW  = MW + SCALE_W + 1;
  localparam int NUMW = SW + 24;
  localparam logic [SIZE_W-1:0] GRID_CLIP = SIZE_W'(MAX_GRID);

  // configuration
  logic [SIZE_W-1:0]  size_q [0:2];
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_RST;
      size_q[1] <= SIZE_RST;
      size_q[2] <= SIZE_RST;
      scale_q   <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_SIZE_DIM1:  size_q[0] <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SIZE_DIM2:  size_q[1] <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SIZE_DIM3:  size_q[2] <= cfg_wdata_i[SIZE_W-1:0];
        CFG_NORM_SCALE: scale_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic             acc;
  logic [COORD_W-1:0] coord [0:2];
  logic [SW-1:0]    xin   [0:5];

  assign acc      = start_i && !busy_o;
  assign coord[0] = coord1_i;
  assign coord[1] = coord2_i;
  assign coord[2] = coord3_i;
  assign xin[0]   = comp1_re_i;
  assign xin[1]   = comp1_im_i;
  assign xin[2]   = comp2_re_i;
  assign xin[3]   = comp2_im_i;
  assign xin[4]   = comp3_re_i;
  assign xin[5]   = comp3_im_i;

  // stage 1: wavenumbers
  logic                     v1_q;
  logic signed [WAVE_W-1:0] w1_q [0:2];
  logic signed [WAVE_W-1:0] g1_q [0:2];
  logic [SW-1:0]            x1_q [0:5];

  for (genvar d = 0; d < 3; d++) begin : g_axis
    logic [SIZE_W-1:0]   nc;
    logic [SIZE_W-1:0]   half;
    logic [SIZE_W:0]     diff;
    logic [WAVE_W-1:0]   w_d;
    assign nc   = (size_q[d] > GRID_CLIP) ? GRID_CLIP : size_q[d];
    assign half = nc >> 1;
    assign diff = {2'b00, coord[d]} - {1'b0, nc};
    assign w_d  = ({1'b0, coord[d]} > half) ? diff[WAVE_W-1:0] : {1'b0, coord[d]};

    always_ff @(posedge clk_i) begin
      w1_q[d] <= w_d;
      g1_q[d] <= ({1'b0, coord[d]} == half) ? '0 : w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      x1_q[i] <= xin[i];
    end
  end

  // stage 2: squares and products
  logic                     v2_q;
  logic [K2_W-2:0]          sq2_q [0:2];
  logic signed [PW-1:0]     pr2_q [0:5];
  logic signed [WAVE_W-1:0] g2_q  [0:2];

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 3; d++) begin
      sq2_q[d] <= (K2_W-1)'(K2_W'(w1_q[d]) * K2_W'(w1_q[d]));
      g2_q[d]  <= g1_q[d];
      for (int p = 0; p < 2; p++) begin
        pr2_q[2*d+p] <= PW'(g1_q[d]) * PW'($signed(x1_q[2*d+p]));
      end
    end
  end

  // stage 3: sums
  logic                     v3_q;
  logic [K2_W-1:0]          k23_q;
  logic signed [SSW-1:0]    s3_q [0:1];
  logic signed [WAVE_W-1:0] g3_q [0:2];

  always_ff @(posedge clk_i) begin
    k23_q <= K2_W'(sq2_q[0]) + K2_W'(sq2_q[1]) + K2_W'(sq2_q[2]);
    for (int p = 0; p < 2; p++) begin
      s3_q[p] <= SSW'(pr2_q[p]) + SSW'(pr2_q[2+p]) + SSW'(pr2_q[4+p]);
    end
    g3_q <= g2_q;
  end

  // stage 4: magnitude times scale, partial products
  logic                     v4_q;
  logic [K2_W-1:0]          k24_q;
  logic [PPW-1:0]           pp4_q [0:1][0:3];
  logic                     sn4_q [0:1];
  logic signed [WAVE_W-1:0] g4_q  [0:2];

  for (genvar p = 0; p < 2; p++) begin : g_scale
    logic [SSW-1:0] sabs;
    logic [MW-1:0]  mag;
    logic [ML-1:0]  mlo;
    logic [MH-1:0]  mhi;
    assign sabs = s3_q[p][SSW-1] ? (SSW'(0) - s3_q[p]) : s3_q[p];
    assign mag  = sabs[MW-1:0];
    assign mlo  = mag[ML-1:0];
    assign mhi  = mag[MW-1:ML];

    always_ff @(posedge clk_i) begin
      pp4_q[p][0] <= PPW'(mlo) * PPW'(scale_q[NL-1:0]);
      pp4_q[p][1] <= PPW'(mhi) * PPW'(scale_q[NL-1:0]);
      pp4_q[p][2] <= PPW'(mlo) * PPW'(scale_q[SCALE_W-1:NL]);
      pp4_q[p][3] <= PPW'(mhi) * PPW'(scale_q[SCALE_W-1:NL]);
      sn4_q[p]    <= s3_q[p][SSW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    k24_q <= k23_q;
    g4_q  <= g3_q;
  end

  // stage 5: rounded scaled magnitude
  logic                     v5_q;
  logic [K2_W-1:0]          k25_q;
  logic [MW-1:0]            a5_q  [0:1];
  logic                     sn5_q [0:1];
  logic signed [WAVE_W-1:0] g5_q  [0:2];

  for (genvar p = 0; p < 2; p++) begin : g_round
    logic [PRW-1:0] sum;
    assign sum = PRW'(pp4_q[p][0]) + (PRW'(pp4_q[p][1]) << ML)
               + (PRW'(pp4_q[p][2]) << NL) + (PRW'(pp4_q[p][3]) << (ML + NL))
               + (PRW'(1) << (SCALE_W - 1));
    always_ff @(posedge clk_i) begin
      a5_q[p]  <= sum[SCALE_W +: MW];
      sn5_q[p] <= sn4_q[p];
    end
  end

  always_ff @(posedge clk_i) begin
    k25_q <= k24_q;
    g5_q  <= g4_q;
  end

  // stage 6: dividend per lane
  logic [K2_W-1:0] k26_q;
  logic [NUMW-1:0] num6_q [0:5];
  sdp_ctl_t        ctl6_q [0:5];
  sdp_ctl_t        ctl6_d [0:5];
  logic [SW-1:0]   res    [0:5];
  logic            lvld   [0:5];

  for (genvar d = 0; d < 3; d++) begin : g_lane_d
    logic [WAVE_W-1:0] gm;
    assign gm = g5_q[d][WAVE_W-1] ? (WAVE_W'(0) - g5_q[d]) : g5_q[d];
    for (genvar p = 0; p < 2; p++) begin : g_lane_p
      assign ctl6_d[2*d+p] = '{vld:  v5_q,
                               neg:  !(sn5_q[p] ^ g5_q[d][WAVE_W-1]),
                               zero: (g5_q[d] == '0)};
      always_ff @(posedge clk_i) begin
        num6_q[2*d+p] <= NUMW'(a5_q[p]) * NUMW'(gm) + NUMW'(k25_q >> 1);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          ctl6_q[2*d+p] <= '0;
        end else begin
          ctl6_q[2*d+p] <= ctl6_d[2*d+p];
        end
      end
      sdp_div #(.SW(SW)) u_div (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl6_q[2*d+p]),
        .num_i  (num6_q[2*d+p]),
        .k2_i   (k26_q),
        .vld_o  (lvld[2*d+p]),
        .res_o  (res[2*d+p])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    k26_q <= k25_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o    = lvld[0] & lvld[1] & lvld[2] & lvld[3] & lvld[4] & lvld[5];
  assign proj1_re_o = res[0];
  assign proj1_im_o = res[1];
  assign proj2_re_o = res[2];
  assign proj2_im_o = res[3];
  assign proj3_re_o = res[4];
  assign proj3_im_o = res[5];

endmodule

`default_nettype wire

// ===== rtl/sdp_div.sv =====
// ----------------------------------------------------------------------------
// sdp_div
// Pipelined restoring divider lane, one quotient bit per stage, with
// overflow detect and signed saturation of the rounded quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_div import sdp_pkg::*; #(
  parameter int SW = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sdp_ctl_t             ctl_i,
  input  wire logic [SW+24-1:0]     num_i,
  input  wire logic [K2_W-1:0]      k2_i,
  output logic                      vld_o,
  output logic [SW-1:0]             res_o
);

  localparam int NUMW = SW + 24;
  localparam logic [SW-1:0] POS_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] NEG_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [NUMW-1:0] rem_q [0:SW-1];
  logic [K2_W-1:0] k2_q  [0:SW-1];
  logic [SW-1:0]   quo_q [0:SW];
  sdp_ctl_t        ctl_q [0:SW];
  logic            ovf_q [0:SW];

  logic [SW-1:0]   res_d, res_q;
  logic            vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    k2_q[0]  <= k2_i;
    quo_q[0] <= '0;
    ovf_q[0] <= num_i >= {K2_W'(k2_i) , {SW{1'b0}}};
  end

  for (genvar j = 0; j < SW; j++) begin : g_stage
    localparam int B = SW - 1 - j;
    logic [NUMW-1:0] sub;
    logic            ge;
    assign sub = NUMW'(k2_q[j]) << B;
    assign ge  = rem_q[j] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j+1] <= '0;
      end else begin
        ctl_q[j+1] <= ctl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[j+1] <= quo_q[j] | (SW'(ge) << B);
      ovf_q[j+1] <= ovf_q[j];
    end

    if (j < SW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[j+1] <= ge ? (rem_q[j] - sub) : rem_q[j];
        k2_q[j+1]  <= k2_q[j];
      end
    end
  end

  always_comb begin
    res_d = quo_q[SW];
    if (ctl_q[SW].zero) begin
      res_d = '0;
    end else if (ctl_q[SW].neg) begin
      if (ovf_q[SW] || (quo_q[SW][SW-1] && (quo_q[SW][SW-2:0] != '0))) begin
        res_d = NEG_MIN;
      end else begin
        res_d = SW'(0) - quo_q[SW];
      end
    end else if (ovf_q[SW] || quo_q[SW][SW-1]) begin
      res_d = POS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_q[SW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/sdp_chk.sv =====
// ----------------------------------------------------------------------------
// sdp_chk
// Port-level checks for the spectral projection bin core.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_chk import sdp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    busy_o,
  input  wire logic [COORD_W-1:0]      coord1_i,
  input  wire logic [COORD_W-1:0]      coord2_i,
  input  wire logic [COORD_W-1:0]      coord3_i,
  input  wire logic                    valid_o,
  input  wire logic [SAMPLE_WIDTH-1:0] proj1_re_o,
  input  wire logic [SAMPLE_WIDTH-1:0] proj1_im_o,
  input  wire logic [SAMPLE_WIDTH-1:0] proj2_re_o,
  input  wire logic [SAMPLE_WIDTH-1:0] proj2_im_o,
  input  wire logic [SAMPLE_WIDTH-1:0] proj3_re_o,
  input  wire logic [SAMPLE_WIDTH-1:0] proj3_im_o
);

  localparam int LAT = SAMPLE_WIDTH + 8;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT valid_o)
    else $error("transaction result missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without transaction");

  a_dc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && coord1_i == '0 && coord2_i == '0 && coord3_i == '0)
    |-> ##LAT (proj1_re_o == '0 && proj1_im_o == '0 && proj2_re_o == '0 &&
               proj2_im_o == '0 && proj3_re_o == '0 && proj3_im_o == '0))
    else $error("zero bin not zero");

endmodule

bind spectral_divfree_projection_bin_core sdp_chk #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sdp_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .coord1_i   (coord1_i),
  .coord2_i   (coord2_i),
  .coord3_i   (coord3_i),
  .valid_o    (valid_o),
  .proj1_re_o (proj1_re_o),
  .proj1_im_o (proj1_im_o),
  .proj2_re_o (proj2_re_o),
  .proj2_im_o (proj2_im_o),
  .proj3_re_o (proj3_re_o),
  .proj3_im_o (proj3_im_o)
);

`default_nettype wire
